// ===== rtl/core/i2cbs_pkg.sv =====
package i2cbs_pkg;

	localparam int BYTE_BITS = 8;
	localparam int CNT_W     = $clog2(BYTE_BITS);

	typedef enum logic [2:0] {
		MODE_START = 3'd0,
		MODE_STOP  = 3'd1,
		MODE_WRITE = 3'd2,
		MODE_READ  = 3'd3,
		MODE_SACK  = 3'd4,
		MODE_RACK  = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START_SDA1,
		ST_START_SCL1,
		ST_START_SDA0,
		ST_START_SCL0,
		ST_STOP_SDA0,
		ST_STOP_SCL1,
		ST_STOP_SDA1,
		ST_BIT_SDA,
		ST_BIT_SCLH,
		ST_BIT_SCLL
	} state_t;

	typedef struct packed {
		logic [2:0]           mode;
		logic [BYTE_BITS-1:0] tx_byte;
		logic                 ack_out;
		logic [BYTE_BITS-1:0] line_samples;
	} cmd_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic [BYTE_BITS-1:0] read_value;
		logic                 last;
	} res_t;

	// one pin write produced by the sequencer
	typedef struct packed {
		logic emit;
		logic scl;
		logic sda;
		logic last;
		logic rd;
	} pin_wr_t;

	typedef struct packed {
		logic load;
		logic tx_shift;
		logic rx_shift;
	} shift_ctl_t;

endpackage

// ===== rtl/core/i2cbs_shift.sv =====
module i2cbs_shift (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2cbs_pkg::shift_ctl_t         ctl,
	input  logic [i2cbs_pkg::BYTE_BITS-1:0] tx_byte,
	input  logic [i2cbs_pkg::BYTE_BITS-1:0] line_samples,
	output logic                          tx_bit,
	output logic [i2cbs_pkg::BYTE_BITS-1:0] rx_value
);
	import i2cbs_pkg::*;

	logic [BYTE_BITS-1:0] tx_q;
	logic [BYTE_BITS-1:0] smp_q;
	logic [BYTE_BITS-1:0] rx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q  <= '0;
			smp_q <= '0;
			rx_q  <= '0;
		end else if (ctl.load) begin
			tx_q  <= tx_byte;
			smp_q <= line_samples;
			rx_q  <= '0;
		end else begin
			if (ctl.tx_shift) begin
				tx_q <= {tx_q[BYTE_BITS-2:0], 1'b0};
			end
			if (ctl.rx_shift) begin
				smp_q <= {smp_q[BYTE_BITS-2:0], 1'b0};
				rx_q  <= {rx_q[BYTE_BITS-2:0], smp_q[BYTE_BITS-1]};
			end
		end
	end

	assign tx_bit   = tx_q[BYTE_BITS-1];
	assign rx_value = rx_q;

endmodule

// ===== rtl/core/i2cbs_ctrl.sv =====
module i2cbs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic                  cmd_acc,
	input  logic [2:0]            mode,
	input  logic                  ack_out,
	input  logic                  tx_bit,
	output logic                  busy,
	output i2cbs_pkg::pin_wr_t    pw,
	output i2cbs_pkg::shift_ctl_t sctl
);
	import i2cbs_pkg::*;

	state_t           state_q, state_d;
	logic [2:0]       mode_q, mode_d;
	logic             ack_q, ack_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             scl_q, sda_q;
	logic             rd_mode;
	logic             cnt_zero;

	assign rd_mode  = (mode_q == MODE_READ) || (mode_q == MODE_RACK);
	assign cnt_zero = (cnt_q == '0);
	assign busy     = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		ack_d   = ack_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					mode_d = mode;
					ack_d  = ack_out;
					cnt_d  = '0;
					case (mode)
						MODE_START: state_d = ST_START_SDA1;
						MODE_STOP:  state_d = ST_STOP_SDA0;
						MODE_WRITE, MODE_READ: begin
							state_d = ST_BIT_SDA;
							cnt_d   = CNT_W'(BYTE_BITS - 1);
						end
						MODE_SACK, MODE_RACK: state_d = ST_BIT_SDA;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_START_SDA1: if (go) state_d = ST_START_SCL1;
			ST_START_SCL1: if (go) state_d = ST_START_SDA0;
			ST_START_SDA0: if (go) state_d = ST_START_SCL0;
			ST_START_SCL0: if (go) state_d = ST_IDLE;
			ST_STOP_SDA0:  if (go) state_d = ST_STOP_SCL1;
			ST_STOP_SCL1:  if (go) state_d = ST_STOP_SDA1;
			ST_STOP_SDA1:  if (go) state_d = ST_IDLE;
			ST_BIT_SDA:    if (go) state_d = ST_BIT_SCLH;
			ST_BIT_SCLH:   if (go) state_d = ST_BIT_SCLL;
			ST_BIT_SCLL: begin
				if (go) begin
					if (cnt_zero) begin
						state_d = ST_IDLE;
					end else begin
						cnt_d = cnt_q - 1'b1;
						// read byte releases sda once, then only clocks
						state_d = (mode_q == MODE_READ) ? ST_BIT_SCLH : ST_BIT_SDA;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pw.emit       = busy && go;
		pw.scl        = scl_q;
		pw.sda        = sda_q;
		pw.last       = 1'b0;
		pw.rd         = 1'b0;
		sctl.load     = cmd_acc;
		sctl.tx_shift = 1'b0;
		sctl.rx_shift = 1'b0;
		case (state_q)
			ST_START_SDA1: pw.sda = 1'b1;
			ST_START_SCL1: pw.scl = 1'b1;
			ST_START_SDA0: pw.sda = 1'b0;
			ST_START_SCL0: begin
				pw.scl  = 1'b0;
				pw.last = 1'b1;
			end
			ST_STOP_SDA0: pw.sda = 1'b0;
			ST_STOP_SCL1: pw.scl = 1'b1;
			ST_STOP_SDA1: begin
				pw.sda  = 1'b1;
				pw.last = 1'b1;
			end
			ST_BIT_SDA: begin
				case (mode_q)
					MODE_WRITE: pw.sda = tx_bit;
					MODE_SACK:  pw.sda = ack_q;
					default:    pw.sda = 1'b1;
				endcase
			end
			ST_BIT_SCLH: begin
				pw.scl        = 1'b1;
				sctl.rx_shift = go && rd_mode;
			end
			ST_BIT_SCLL: begin
				pw.scl        = 1'b0;
				pw.last       = cnt_zero;
				pw.rd         = cnt_zero && rd_mode;
				sctl.tx_shift = go;
			end
			default: pw.emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_START;
			ack_q   <= 1'b0;
			cnt_q   <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			ack_q   <= ack_d;
			cnt_q   <= cnt_d;
			if (pw.emit) begin
				scl_q <= pw.scl;
				sda_q <= pw.sda;
			end
		end
	end

`ifndef SYNTH
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pw.emit && pw.last) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after final pin write");

	a_start_leaves_low: assert property (@(posedge clk) disable iff (!arst_n)
		(pw.emit && state_q == ST_START_SCL0) |=> (!scl_q && !sda_q))
		else $error("start did not leave both lines low");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!pw.emit |=> $stable({scl_q, sda_q}))
		else $error("line levels changed without a pin write");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BYTE_BITS - 1))
		else $error("bit counter out of range");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !sctl.load)
		else $error("shift register loaded mid command");
`endif

endmodule

// ===== rtl/core/i2c_master_bit_sequencer.sv =====
// channel  | signals                        | moves
// ---------+--------------------------------+------------------------------------
// cmd      | cmd_valid, cmd_stall, cmd      | one request: mode and its operands
// res      | res_valid, res_stall, res      | one pin write: scl, sda, read, last
//
// one pin write per cycle while res is not stalled; a request has 3 to 24 pin
// writes (write byte 24) and is accepted while idle, with no pin write.
// bit pacing is set by the sequencer state machine and its bit counter.
// reset leaves both lines released high and the sequencer idle.
// cmd_stall is high while a request is being played out; a stalled result
// is held in the output register and the sequencer waits.
module i2c_master_bit_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  i2cbs_pkg::cmd_t   cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output i2cbs_pkg::res_t   res
);
	import i2cbs_pkg::*;

	logic                 go;
	logic                 cmd_acc;
	logic                 busy;
	logic                 tx_bit;
	logic [BYTE_BITS-1:0] rx_value;
	pin_wr_t              pw;
	shift_ctl_t           sctl;
	logic                 res_valid_q;
	res_t                 res_q;

	assign go        = !res_valid_q || !res_stall;
	assign cmd_stall = busy;
	assign cmd_acc   = cmd_valid && !busy;

	i2cbs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.cmd_acc (cmd_acc),
		.mode    (cmd.mode),
		.ack_out (cmd.ack_out),
		.tx_bit  (tx_bit),
		.busy    (busy),
		.pw      (pw),
		.sctl    (sctl)
	);

	i2cbs_shift u_shift (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (sctl),
		.tx_byte      (cmd.tx_byte),
		.line_samples (cmd.line_samples),
		.tx_bit       (tx_bit),
		.rx_value     (rx_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= pw.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pw.emit) begin
			res_q.scl_level  <= pw.scl;
			res_q.sda_level  <= pw.sda;
			res_q.read_value <= pw.rd ? rx_value : '0;
			res_q.last       <= pw.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
